### hdl/plbct_pkg.sv
// Shared types and constants for the block cache tag engine.
// No dependencies; imported by every module in hdl/.
package plbct_pkg;

  localparam int unsigned SLOTS              = 64;
  localparam int unsigned SECTORS_PER_BUFFER = 8;
  localparam int unsigned POS_W              = 6;
  localparam int unsigned IN_DATA_W          = 48;
  localparam int unsigned OUT_DATA_W         = 48;
  localparam logic [7:0]  REF_MAX            = 8'hFF;

  typedef enum logic [2:0] {
    CMD_ACQUIRE    = 3'd0,
    CMD_RELEASE    = 3'd1,
    CMD_PIN        = 3'd2,
    CMD_UNPIN      = 3'd3,
    CMD_MARK_DIRTY = 3'd4,
    CMD_FLUSH      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_VICT  = 2'd1,
    ST_REF_ERR  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_FLUSH
  } state_t;

  // One LRU list entry; the cell at position 0 is the list front.
  typedef struct packed {
    logic [5:0]  slot_id;
    logic        assigned;
    logic [2:0]  dev;
    logic [30:0] base;
    logic [7:0]  refcnt;
    logic        dirty;
  } entry_t;

  typedef struct packed {
    logic [2:0]  dev;
    logic [30:0] base;
    logic [5:0]  slot;
  } key_t;

  typedef struct packed {
    logic tag_hit;
    logic unref;
    logic slot_eq;
  } flags_t;

  typedef struct packed {
    logic write;
    logic take_prev;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] wb_base;
    logic [2:0]  wb_dev;
    logic        wb_needed;
    logic        fill_needed;
    logic        hit;
    logic [5:0]  slot_index;
  } result_t;

endpackage

### hdl/plbct_cell.sv
// One position of the LRU chain: holds an entry, compares it against the key.
// Depends on plbct_pkg.
module plbct_cell import plbct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [5:0] rst_slot,
  input  entry_t     prev_entry,
  input  entry_t     wr_entry,
  input  cell_ctl_t  ctl,
  input  key_t       key,
  output entry_t     entry,
  output flags_t     flags
);

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r         <= '0;
      entry_r.slot_id <= rst_slot;
    end else if (ctl.write) begin
      entry_r <= wr_entry;
    end else if (ctl.take_prev) begin
      entry_r <= prev_entry;
    end
  end

  assign entry = entry_r;

  always_comb begin
    flags.tag_hit = entry_r.assigned && (entry_r.dev == key.dev) && (entry_r.base == key.base);
    flags.unref   = (entry_r.refcnt == 8'd0);
    flags.slot_eq = (entry_r.slot_id == key.slot);
  end

endmodule

### hdl/pinned_lru_block_cache_tags.sv
// Block cache tag engine: LRU list kept as a chain of cells, front at cell 0.
// Order: the item is accepted in idle, looked up, then executed into the output
// register; a held output register stalls execute until out_tready. A new item is
// taken only in idle, after the last one is executed; flush then scans one
// list position per cycle up to the last dirty one, plus output stalls.
// Reset (rst_n low, synchronous): all slots free, clean, count 0, slot i at position i.
// Depends on plbct_pkg and plbct_cell.
module pinned_lru_block_cache_tags import plbct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // command[2:0], device_id[5:3], sector[36:6], slot[42:37], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // slot_index[5:0], hit[6], fill_needed[7], writeback_needed[8],
  // writeback_device[11:9], writeback_base[42:12], status[44:43], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  state_t          state_r, state_nxt;
  logic [2:0]      cmd_r;
  key_t            key_r;
  logic [POS_W-1:0] pos_r, pos_nxt, p_r, p_nxt, rd_idx;
  logic            hit_r, found_r;
  result_t         out_r, res;
  logic            out_valid_r, out_last_r, res_last, out_load;
  logic            wr_en, mtf, can_out;
  entry_t          wr_entry, cur;
  entry_t          cells [SLOTS];
  flags_t          flg   [SLOTS];
  cell_ctl_t       ctl   [SLOTS];
  logic [SLOTS-1:0] dirty_vec;
  logic            any_dirty, more_dirty;
  logic            hf, vf, sf;
  logic [POS_W-1:0] hidx, vidx, sidx;
  logic [30:0]     in_base;

  assign in_tready = (state_r == S_IDLE);
  assign in_base   = 31'(in_tdata[36:6] / SECTORS_PER_BUFFER * SECTORS_PER_BUFFER);

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      plbct_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .rst_slot  (6'(gi)),
        .prev_entry((gi == 0) ? wr_entry : cells[(gi == 0) ? 0 : gi - 1]),
        .wr_entry  (wr_entry),
        .ctl       (ctl[gi]),
        .key       (key_r),
        .entry     (cells[gi]),
        .flags     (flg[gi])
      );
      assign dirty_vec[gi]     = cells[gi].dirty;
      assign ctl[gi].write     = wr_en && (mtf ? (gi == 0) : (6'(gi) == rd_idx));
      assign ctl[gi].take_prev = mtf && (gi != 0) && (6'(gi) <= rd_idx);
    end
  endgenerate

  assign any_dirty = |dirty_vec;
  assign rd_idx    = (state_r == S_FLUSH) ? p_r : pos_r;
  assign cur       = cells[rd_idx];
  assign can_out   = !out_valid_r || out_tready;

  // Front-most tag hit, tail-most unreferenced cell, cell holding the slot.
  always_comb begin
    hf = 1'b0; vf = 1'b0; sf = 1'b0;
    hidx = '0; vidx = '0; sidx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (flg[i].tag_hit) begin
        hf = 1'b1; hidx = POS_W'(i);
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (flg[i].unref) begin
        vf = 1'b1; vidx = POS_W'(i);
      end
      if (flg[i].slot_eq) begin
        sf = 1'b1; sidx = POS_W'(i);
      end
    end
    pos_nxt = (cmd_r == CMD_ACQUIRE) ? (hf ? hidx : vidx) : sidx;
  end

  always_comb begin
    more_dirty = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (6'(i) > p_r && dirty_vec[i]) more_dirty = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    wr_en     = 1'b0;
    mtf       = 1'b0;
    wr_entry  = cur;
    out_load  = 1'b0;
    res       = '0;
    res_last  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_LOOK;
      end
      S_LOOK: state_nxt = S_EXEC;
      S_EXEC: begin
        if (can_out) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          case (cmd_r)
            CMD_ACQUIRE: begin
              if (hit_r) begin
                res.slot_index = cur.slot_id;
                res.hit        = 1'b1;
                if (cur.refcnt == REF_MAX) begin
                  res.status = ST_REF_ERR;
                end else begin
                  wr_en           = 1'b1;
                  wr_entry.refcnt = cur.refcnt + 8'd1;
                end
              end else if (found_r) begin
                res.slot_index  = cur.slot_id;
                res.fill_needed = 1'b1;
                res.wb_needed   = cur.dirty;
                res.wb_dev      = cur.dirty ? cur.dev : 3'd0;
                res.wb_base     = cur.dirty ? cur.base : 31'd0;
                wr_en             = 1'b1;
                wr_entry.assigned = 1'b1;
                wr_entry.dev      = key_r.dev;
                wr_entry.base     = key_r.base;
                wr_entry.refcnt   = 8'd1;
                wr_entry.dirty    = 1'b0;
              end else begin
                res.status = ST_NO_VICT;
              end
            end
            CMD_RELEASE, CMD_UNPIN: begin
              res.slot_index = key_r.slot;
              if (cur.refcnt == 8'd0) begin
                res.status = ST_REF_ERR;
              end else begin
                wr_en           = 1'b1;
                wr_entry.refcnt = cur.refcnt - 8'd1;
                mtf = (cmd_r == CMD_RELEASE) && (cur.refcnt == 8'd1);
              end
            end
            CMD_PIN: begin
              res.slot_index = key_r.slot;
              if (cur.refcnt == REF_MAX) begin
                res.status = ST_REF_ERR;
              end else begin
                wr_en           = 1'b1;
                wr_entry.refcnt = cur.refcnt + 8'd1;
              end
            end
            CMD_MARK_DIRTY: begin
              res.slot_index = key_r.slot;
              if (cur.assigned) begin
                wr_en          = 1'b1;
                wr_entry.dirty = 1'b1;
              end
            end
            CMD_FLUSH: begin
              // Nothing dirty: answer with one empty item.
              if (any_dirty) begin
                out_load  = 1'b0;
                p_nxt     = '0;
                state_nxt = S_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FLUSH: begin
        if (cur.dirty) begin
          if (can_out) begin
            out_load       = 1'b1;
            res.slot_index = cur.slot_id;
            res.wb_needed  = 1'b1;
            res.wb_dev     = cur.dev;
            res.wb_base    = cur.base;
            res_last       = !more_dirty;
            wr_en          = 1'b1;
            wr_entry.dirty = 1'b0;
            p_nxt          = p_r + 1'b1;
            if (!more_dirty) state_nxt = S_IDLE;
          end
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_r         <= '0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      cmd_r     <= in_tdata[2:0];
      key_r.dev <= in_tdata[5:3];
      key_r.base <= in_base;
      key_r.slot <= in_tdata[42:37];
    end
    if (state_r == S_LOOK) begin
      pos_r   <= pos_nxt;
      hit_r   <= hf;
      found_r <= vf;
    end
    if (out_load) begin
      out_r      <= res;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r};
  assign out_tlast  = out_last_r;

endmodule
